/* sv/vot_pkg.sv */
// shared types and constants for the volume overlap tester
// no dependencies; used by vot_axis and volume_overlap_tester

package vot_pkg;

    localparam int COORD_BITS    = 24;
    localparam int NUM_AXES      = 3;
    localparam int RAD_BITS      = COORD_BITS + 1;
    localparam int SQ_BITS       = 2 * COORD_BITS;
    localparam int SUM_BITS      = SQ_BITS + 2;
    localparam int NUM_STG       = 5;
    localparam int IN_DATA_BITS  = ((2 * NUM_AXES * COORD_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_BITS = 8;
    localparam int CFG_IDX_BITS  = 3;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_BITS-1:0] REG_KIND = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_A_X  = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_A_Y  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_A_Z  = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_B_X  = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_B_Y  = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_B_Z  = 3'd6;

    // volume kinds
    localparam logic KIND_BOX    = 1'b0;
    localparam logic KIND_SPHERE = 1'b1;

    // pair test: reference kind first, incoming kind second
    typedef enum logic [1:0] {
        MODE_BB,
        MODE_BS,
        MODE_SB,
        MODE_SS
    } t_mode;

    // per-lane stage loads and test mode
    typedef struct packed {
        logic  ld1;
        logic  ld2;
        logic  ld3;
        t_mode mode;
    } t_axis_ctl;

endpackage

/* sv/vot_axis.sv */
// one axis lane: interval test, clamp, absolute distance and square
// depends on vot_pkg

module vot_axis (
    input  logic                                   i_clk,
    input  vot_pkg::t_axis_ctl                     i_ctl,
    input  logic signed [vot_pkg::COORD_BITS-1:0]  i_ref_a,
    input  logic signed [vot_pkg::COORD_BITS-1:0]  i_ref_b,
    input  logic signed [vot_pkg::COORD_BITS-1:0]  i_in_a,
    input  logic signed [vot_pkg::COORD_BITS-1:0]  i_in_b,
    output logic                                   o_bb_ok,
    output logic [vot_pkg::SQ_BITS-1:0]            o_sq
);

    logic signed [vot_pkg::COORD_BITS-1:0] w_bmin;
    logic signed [vot_pkg::COORD_BITS-1:0] w_bmax;
    logic signed [vot_pkg::COORD_BITS-1:0] w_ctr;
    logic signed [vot_pkg::COORD_BITS-1:0] n_p;
    logic signed [vot_pkg::COORD_BITS-1:0] n_c;
    logic                                  n_bb_ok;
    logic signed [vot_pkg::RAD_BITS-1:0]   w_dif;
    logic [vot_pkg::RAD_BITS-1:0]          w_mag;
    logic [vot_pkg::COORD_BITS-1:0]        n_d;
    logic [vot_pkg::SQ_BITS-1:0]           n_sq;

    logic signed [vot_pkg::COORD_BITS-1:0] r_p;
    logic signed [vot_pkg::COORD_BITS-1:0] r_c;
    logic                                  r_bb_ok;
    logic [vot_pkg::COORD_BITS-1:0]        r_d;
    logic [vot_pkg::SQ_BITS-1:0]           r_sq;

    // stage 1: pick box and center, clamp; two spheres take the reference center
    always_comb begin
        n_bb_ok = (i_ref_b >= i_in_a) && (i_ref_a <= i_in_b);
        w_bmin  = i_ref_a;
        w_bmax  = i_ref_b;
        w_ctr   = i_in_a;
        case (i_ctl.mode)
            vot_pkg::MODE_BS: begin
                w_bmin = i_ref_a;
                w_bmax = i_ref_b;
                w_ctr  = i_in_a;
            end
            vot_pkg::MODE_SB: begin
                w_bmin = i_in_a;
                w_bmax = i_in_b;
                w_ctr  = i_ref_a;
            end
            default: begin
                w_bmin = i_ref_a;
                w_bmax = i_ref_b;
                w_ctr  = i_in_a;
            end
        endcase
        if (i_ctl.mode == vot_pkg::MODE_SS) begin
            n_p = i_ref_a;
        end else if (w_ctr > w_bmax) begin
            n_p = w_bmax;
        end else if (w_ctr < w_bmin) begin
            n_p = w_bmin;
        end else begin
            n_p = w_ctr;
        end
        n_c = w_ctr;
    end

    // stage 2: absolute difference, always below 2^COORD_BITS
    always_comb begin
        w_dif = vot_pkg::RAD_BITS'(r_p) - vot_pkg::RAD_BITS'(r_c);
        w_mag = w_dif[vot_pkg::RAD_BITS-1] ? (~w_dif + 1'b1) : w_dif;
        n_d   = w_mag[vot_pkg::COORD_BITS-1:0];
    end

    // stage 3: square
    assign n_sq = vot_pkg::SQ_BITS'(r_d) * vot_pkg::SQ_BITS'(r_d);

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld1) begin
            r_p     <= n_p;
            r_c     <= n_c;
            r_bb_ok <= n_bb_ok;
        end
        if (i_ctl.ld2) begin
            r_d <= n_d;
        end
        if (i_ctl.ld3) begin
            r_sq <= n_sq;
        end
    end

    assign o_bb_ok = r_bb_ok;
    assign o_sq    = r_sq;

endmodule

/* sv/volume_overlap_tester.sv */
// volume overlap tester top level: config registers, five stage pipeline
// depends on vot_pkg and vot_axis

// channel   | dir | signals                         | contents
// ----------+-----+---------------------------------+----------------------------------
// s_axis    | in  | tvalid tready tdata[143:0] tuser| incoming volume item
// m_axis    | out | tvalid tready tdata[7:0]        | hit result item
// cfg       | in  | i_cfg_we i_cfg_idx i_cfg_wdata  | reference volume registers
//
// an accepted item passes through five register stages (clamp, distance,
// square, sum, compare); they take one item per cycle while the output
// is not stalled, and a result leaves when m_axis_tready is high.
// valid bits travel with the data and a stage loads when empty or when the
// one after it moves, so bubbles close up under a stalled output; reset
// clears every valid bit and the reference registers (box at the origin).

module volume_overlap_tester (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // fields low to high: in_a_x, in_a_y, in_a_z, in_b_x, in_b_y, in_b_z
    input  logic [vot_pkg::IN_DATA_BITS-1:0]      s_axis_tdata,
    // fields: req_type
    input  logic                                  s_axis_tuser,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // fields: hit (bit 0), rest zero
    output logic [vot_pkg::OUT_DATA_BITS-1:0]     m_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    input  logic                                  i_cfg_we,
    input  logic [vot_pkg::CFG_IDX_BITS-1:0]      i_cfg_idx,
    input  logic [vot_pkg::COORD_BITS-1:0]        i_cfg_wdata
);

    // reference volume
    logic                                  r_ref_kind;
    logic signed [vot_pkg::COORD_BITS-1:0] r_ref_a [vot_pkg::NUM_AXES];
    logic signed [vot_pkg::COORD_BITS-1:0] r_ref_b [vot_pkg::NUM_AXES];

    // incoming fields
    logic signed [vot_pkg::COORD_BITS-1:0] w_in_a [vot_pkg::NUM_AXES];
    logic signed [vot_pkg::COORD_BITS-1:0] w_in_b [vot_pkg::NUM_AXES];

    // pipeline control
    logic [vot_pkg::NUM_STG-1:0] r_vld;
    logic [vot_pkg::NUM_STG-1:0] n_vld;
    logic [vot_pkg::NUM_STG-1:0] w_ld;
    vot_pkg::t_mode              n_mode;
    vot_pkg::t_axis_ctl          w_axis_ctl;

    // lane outputs
    logic                         w_bb_ok [vot_pkg::NUM_AXES];
    logic [vot_pkg::SQ_BITS-1:0]  w_sq    [vot_pkg::NUM_AXES];

    // radius path
    logic signed [vot_pkg::RAD_BITS-1:0] n_rad;
    logic [vot_pkg::SQ_BITS-1:0]         n_rr;
    logic [vot_pkg::SUM_BITS-1:0]        n_sum;
    logic                                n_hit;

    // stage registers
    vot_pkg::t_mode                      r_s1_mode;
    logic signed [vot_pkg::RAD_BITS-1:0] r_s1_rad;
    vot_pkg::t_mode                      r_s2_mode;
    logic                                r_s2_neg;
    logic                                r_s2_bb;
    logic [vot_pkg::COORD_BITS-1:0]      r_s2_rmag;
    vot_pkg::t_mode                      r_s3_mode;
    logic                                r_s3_neg;
    logic                                r_s3_bb;
    logic [vot_pkg::SQ_BITS-1:0]         r_s3_rr;
    vot_pkg::t_mode                      r_s4_mode;
    logic                                r_s4_neg;
    logic                                r_s4_bb;
    logic [vot_pkg::SQ_BITS-1:0]         r_s4_rr;
    logic [vot_pkg::SUM_BITS-1:0]        r_s4_sum;
    logic                                r_s5_hit;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_kind <= vot_pkg::KIND_BOX;
            for (int i = 0; i < vot_pkg::NUM_AXES; i++) begin
                r_ref_a[i] <= '0;
                r_ref_b[i] <= '0;
            end
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                vot_pkg::REG_KIND: r_ref_kind <= i_cfg_wdata[0];
                vot_pkg::REG_A_X:  r_ref_a[0] <= i_cfg_wdata;
                vot_pkg::REG_A_Y:  r_ref_a[1] <= i_cfg_wdata;
                vot_pkg::REG_A_Z:  r_ref_a[2] <= i_cfg_wdata;
                vot_pkg::REG_B_X:  r_ref_b[0] <= i_cfg_wdata;
                vot_pkg::REG_B_Y:  r_ref_b[1] <= i_cfg_wdata;
                vot_pkg::REG_B_Z:  r_ref_b[2] <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // unpack incoming coordinates
    always_comb begin
        for (int i = 0; i < vot_pkg::NUM_AXES; i++) begin
            w_in_a[i] = s_axis_tdata[i*vot_pkg::COORD_BITS +: vot_pkg::COORD_BITS];
            w_in_b[i] = s_axis_tdata[(vot_pkg::NUM_AXES+i)*vot_pkg::COORD_BITS
                                     +: vot_pkg::COORD_BITS];
        end
    end

    // stage loads: a stage takes new data when empty or when it drains
    always_comb begin
        w_ld[vot_pkg::NUM_STG-1] = !r_vld[vot_pkg::NUM_STG-1] || m_axis_tready;
        for (int k = vot_pkg::NUM_STG - 2; k >= 0; k--) begin
            w_ld[k] = !r_vld[k] || w_ld[k+1];
        end
        n_vld[0] = s_axis_tvalid;
        for (int k = 1; k < vot_pkg::NUM_STG; k++) begin
            n_vld[k] = r_vld[k-1];
        end
    end

    assign s_axis_tready = w_ld[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < vot_pkg::NUM_STG; k++) begin
                if (w_ld[k]) begin
                    r_vld[k] <= n_vld[k];
                end
            end
        end
    end

    // pair mode from reference kind and incoming kind
    always_comb begin
        case ({r_ref_kind, s_axis_tuser})
            {vot_pkg::KIND_BOX, vot_pkg::KIND_BOX}:       n_mode = vot_pkg::MODE_BB;
            {vot_pkg::KIND_BOX, vot_pkg::KIND_SPHERE}:    n_mode = vot_pkg::MODE_BS;
            {vot_pkg::KIND_SPHERE, vot_pkg::KIND_BOX}:    n_mode = vot_pkg::MODE_SB;
            default:                                      n_mode = vot_pkg::MODE_SS;
        endcase
    end

    // stage 1 radius: the sphere's radius, the sum for two spheres, zero for two boxes
    always_comb begin
        case (n_mode)
            vot_pkg::MODE_SS: n_rad = vot_pkg::RAD_BITS'(r_ref_b[0])
                                    + vot_pkg::RAD_BITS'(w_in_b[0]);
            vot_pkg::MODE_BS: n_rad = vot_pkg::RAD_BITS'(w_in_b[0]);
            vot_pkg::MODE_SB: n_rad = vot_pkg::RAD_BITS'(r_ref_b[0]);
            default:          n_rad = '0;
        endcase
    end

    assign w_axis_ctl.ld1  = w_ld[0];
    assign w_axis_ctl.ld2  = w_ld[1];
    assign w_axis_ctl.ld3  = w_ld[2];
    assign w_axis_ctl.mode = n_mode;

    // lanes hold their own stage 1..3 registers
    for (genvar g = 0; g < vot_pkg::NUM_AXES; g++) begin : g_axis
        vot_axis u_axis (
            .i_clk   (i_clk),
            .i_ctl   (w_axis_ctl),
            .i_ref_a (r_ref_a[g]),
            .i_ref_b (r_ref_b[g]),
            .i_in_a  (w_in_a[g]),
            .i_in_b  (w_in_b[g]),
            .o_bb_ok (w_bb_ok[g]),
            .o_sq    (w_sq[g])
        );
    end

    // squared radius, sum of squares and the final decision
    assign n_rr  = vot_pkg::SQ_BITS'(r_s2_rmag) * vot_pkg::SQ_BITS'(r_s2_rmag);
    assign n_sum = vot_pkg::SUM_BITS'(w_sq[0]) + vot_pkg::SUM_BITS'(w_sq[1])
                 + vot_pkg::SUM_BITS'(w_sq[2]);

    always_comb begin
        if (r_s4_mode == vot_pkg::MODE_BB) begin
            n_hit = r_s4_bb;
        end else begin
            // negative radius never touches anything
            n_hit = !r_s4_neg && (r_s4_sum <= vot_pkg::SUM_BITS'(r_s4_rr));
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ld[0]) begin
            r_s1_mode <= n_mode;
            r_s1_rad  <= n_rad;
        end
        if (w_ld[1]) begin
            r_s2_mode <= r_s1_mode;
            r_s2_neg  <= r_s1_rad[vot_pkg::RAD_BITS-1];
            r_s2_rmag <= r_s1_rad[vot_pkg::COORD_BITS-1:0];
            r_s2_bb   <= w_bb_ok[0] && w_bb_ok[1] && w_bb_ok[2];
        end
        if (w_ld[2]) begin
            r_s3_mode <= r_s2_mode;
            r_s3_neg  <= r_s2_neg;
            r_s3_bb   <= r_s2_bb;
            r_s3_rr   <= n_rr;
        end
        if (w_ld[3]) begin
            r_s4_mode <= r_s3_mode;
            r_s4_neg  <= r_s3_neg;
            r_s4_bb   <= r_s3_bb;
            r_s4_rr   <= r_s3_rr;
            r_s4_sum  <= n_sum;
        end
        if (w_ld[4]) begin
            r_s5_hit <= n_hit;
        end
    end

    assign m_axis_tvalid = r_vld[vot_pkg::NUM_STG-1];
    assign m_axis_tdata  = vot_pkg::OUT_DATA_BITS'(r_s5_hit);

    // reset empties the whole pipe
    assert property (@(posedge i_clk) !i_rst_n |=> (r_vld == '0))
        else $error("pipeline not empty after reset");

    // input side stalls only when every stage holds an item
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (&r_vld))
        else $error("input stalled with a bubble in the pipeline");

    // a blocked stage keeps its item
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[1] && !w_ld[2]) |=> (r_vld[1] && $stable(r_s2_rmag) && $stable(r_s2_bb)))
        else $error("stalled stage lost its item");

    // after a drain with no new item the stage empties
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ld[3] && !r_vld[2]) |=> !r_vld[3])
        else $error("stage valid invented");

endmodule
